FILE: rtl/core/fta_pkg.sv
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types and constants of the temporal frame averager: configuration
// register map, reset values and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fta_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int FLEN_CFG_W  = 13;
    localparam int NAVG_CFG_W  = 9;

    localparam logic [CFG_IDX_W-1:0]  REG_FRAME_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_NUM_AVGS     = 1'd1;

    localparam logic [FLEN_CFG_W-1:0] FLEN_RESET = 13'd4096;
    localparam logic [NAVG_CFG_W-1:0] NAVG_RESET = 9'd1;

    typedef struct packed {
        logic capture;
        logic accum;
        logic div_step;
        logic load_out;
    } fta_cmd_t;

    typedef struct packed {
        logic group_last;
        logic div_last;
        logic out_free;
    } fta_status_t;

endpackage

FILE: rtl/core/fta_ram.sv
// ----------------------------------------------------------------------------
// fta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fta_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fta_ctrl.sv
// ----------------------------------------------------------------------------
// fta_ctrl
// Sequencer of the temporal frame averager: takes one sample, updates its
// accumulator, runs the divider for output frames and hands off the result.
// ----------------------------------------------------------------------------
module fta_ctrl import fta_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    output fta_cmd_t    cmd,
    input  fta_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCUM  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                state_next = status.group_last ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/fta_datapath.sv
// ----------------------------------------------------------------------------
// fta_datapath
// Configuration registers, frame position, accumulator memory, restoring
// divider and output register of the temporal frame averager.
// ----------------------------------------------------------------------------
module fta_datapath import fta_pkg::*; #(
    parameter int FRAME_MAX   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_AVGS    = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    input  fta_cmd_t                      cmd,
    output fta_status_t                   status,
    input  logic                          result_ready,
    output logic                          result_valid,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic                          last
);

    localparam int IDX_W  = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
    localparam int FLEN_W = $clog2(FRAME_MAX + 1);
    localparam int FCMP_W = (FLEN_W > FLEN_CFG_W) ? FLEN_W : FLEN_CFG_W;
    localparam int AVG_W  = $clog2(MAX_AVGS + 1);
    localparam int ACMP_W = (AVG_W > NAVG_CFG_W) ? AVG_W : NAVG_CFG_W;
    localparam int CNT_W  = $clog2(MAX_AVGS);
    localparam int ACC_W  = SAMPLE_BITS + CNT_W;
    localparam int STEP_W = $clog2(ACC_W);

    logic [FLEN_CFG_W-1:0]  frame_length_reg;
    logic [NAVG_CFG_W-1:0]  num_avgs_reg;
    logic [FCMP_W-1:0]      flen_raw;
    logic [FLEN_W-1:0]      flen_eff;
    logic [ACMP_W-1:0]      navg_raw;
    logic [AVG_W-1:0]       navg_eff;

    logic [IDX_W-1:0]       element_index_reg;
    logic [CNT_W-1:0]       frame_count_reg;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   first_reg;

    logic [IDX_W-1:0]       raddr;
    logic [ACC_W-1:0]       rdata;
    logic [ACC_W-1:0]       sample_ext;
    logic [ACC_W-1:0]       sum;
    logic [ACC_W-1:0]       mag;
    logic                   frame_end;
    logic                   group_last;

    logic [ACC_W-1:0]       quo_reg;
    logic [AVG_W-1:0]       rem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   neg_reg;
    logic                   last_pend_reg;
    logic [AVG_W:0]         rem_sh;
    logic                   rem_ge;
    logic [AVG_W:0]         rem_diff;
    logic [ACC_W-1:0]       quo_signed;

    logic                          result_valid_reg;
    logic [SAMPLE_BITS-1:0]        average_reg;
    logic                          last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FLEN_RESET;
            num_avgs_reg     <= NAVG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_LENGTH: frame_length_reg <= cfg_data[FLEN_CFG_W-1:0];
                REG_NUM_AVGS:     num_avgs_reg     <= cfg_data[NAVG_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        flen_raw = FCMP_W'(frame_length_reg);
        if (flen_raw == '0)
        begin
            flen_eff = FLEN_W'(1);
        end
        else if (flen_raw > FCMP_W'(FRAME_MAX))
        begin
            flen_eff = FLEN_W'(FRAME_MAX);
        end
        else
        begin
            flen_eff = FLEN_W'(flen_raw);
        end

        navg_raw = ACMP_W'(num_avgs_reg);
        if (navg_raw == '0)
        begin
            navg_eff = AVG_W'(1);
        end
        else if (navg_raw > ACMP_W'(MAX_AVGS))
        begin
            navg_eff = AVG_W'(MAX_AVGS);
        end
        else
        begin
            navg_eff = AVG_W'(navg_raw);
        end
    end

    assign raddr = restart ? '0 : element_index_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            idx_reg    <= restart ? '0 : element_index_reg;
            cnt_reg    <= restart ? '0 : frame_count_reg;
            first_reg  <= restart | (frame_count_reg == '0);
        end
    end

    fta_ram #(
        .WIDTH (ACC_W),
        .DEPTH (FRAME_MAX)
    ) u_sums (
        .clk   (clk),
        .we    (cmd.accum),
        .waddr (idx_reg),
        .wdata (sum),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        sample_ext = {{(ACC_W - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
        sum        = first_reg ? sample_ext : rdata + sample_ext;
        mag        = sum[ACC_W-1] ? (~sum + ACC_W'(1)) : sum;
        frame_end  = (FLEN_W'(idx_reg) + FLEN_W'(1)) >= flen_eff;
        group_last = (AVG_W'(cnt_reg) + AVG_W'(1)) >= navg_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_index_reg <= '0;
            frame_count_reg   <= '0;
        end
        else if (cmd.accum)
        begin
            if (frame_end)
            begin
                element_index_reg <= '0;
                frame_count_reg   <= group_last ? '0 : cnt_reg + CNT_W'(1);
            end
            else
            begin
                element_index_reg <= idx_reg + IDX_W'(1);
                frame_count_reg   <= cnt_reg;
            end
        end
    end

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[ACC_W-1]};
        rem_ge   = rem_sh >= {1'b0, navg_eff};
        rem_diff = rem_sh - {1'b0, navg_eff};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            quo_reg       <= mag;
            rem_reg       <= '0;
            step_reg      <= STEP_W'(ACC_W - 1);
            neg_reg       <= sum[ACC_W-1];
            last_pend_reg <= frame_end;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[ACC_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[AVG_W-1:0] : rem_sh[AVG_W-1:0];
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign quo_signed = neg_reg ? (~quo_reg + ACC_W'(1)) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            average_reg <= quo_signed[SAMPLE_BITS-1:0];
            last_reg    <= last_pend_reg;
        end
    end

    assign status.group_last = group_last;
    assign status.div_last   = (step_reg == '0);
    assign status.out_free   = ~result_valid_reg | result_ready;

    assign result_valid = result_valid_reg;
    assign average      = average_reg;
    assign last         = last_reg;

endmodule

FILE: rtl/core/frame_temporal_averager.sv
// ----------------------------------------------------------------------------
// frame_temporal_averager
// Averages groups of num_avgs frames element by element and streams out the
// truncated mean during the last frame of each group.
// ----------------------------------------------------------------------------
// One sample at a time: a sample outside the last frame of a group passes
// through accept, then accumulator read-modify-write on the sample memory.
// A sample in the last frame of a group also runs the bit-serial restoring
// divider that forms sum / num_avgs; a further wait occurs only while the
// previous result still sits unaccepted in the output register. The sample
// memory needs no clearing pass: the first frame of each group writes every
// entry before it is read. Configuration writes are always accepted and may
// only be issued while no sample is in flight. Restart discards the pending
// group and makes its sample element 0 of a new group.
// ----------------------------------------------------------------------------
module frame_temporal_averager import fta_pkg::*; #(
    parameter int FRAME_MAX   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_AVGS    = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic                          last
);

    fta_cmd_t    cmd;
    fta_status_t status;

    assign cfg_ready = 1'b1;

    fta_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .status     (status)
    );

    fta_datapath #(
        .FRAME_MAX   (FRAME_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_AVGS    (MAX_AVGS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .restart      (restart),
        .cmd          (cmd),
        .status       (status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .average      (average),
        .last         (last)
    );

endmodule

FILE: rtl/core/fta_checker.sv
// ----------------------------------------------------------------------------
// fta_checker
// Port-level checks of the temporal frame averager, bound to the top level.
// ----------------------------------------------------------------------------
module fta_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic signed [SAMPLE_BITS-1:0] average,
    input logic                          last
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(average) && $stable(last))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second transaction taken while a sample is in flight");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !$rose(result_valid))
        else $error("result appeared before the accumulator update");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result loaded while the input side was idle");

endmodule

bind frame_temporal_averager fta_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .average      (average),
    .last         (last)
);
